FILE: src/mgd_pkg.sv
// mgd_pkg: shared types, constants and the morse lookup table for the
// gap timed morse decoder; no dependencies
`timescale 1ns / 1ps
`default_nettype none

package mgd_pkg;

    localparam int MAX_ELEMENTS_DEF = 7;

    // longest pattern present in the table
    localparam int LOOKUP_MAX_LEN = 6;

    localparam int KIND_W = 2;
    localparam int TIME_W = 32;
    localparam int GAP_W = 16;
    localparam int CHAR_W = 7;
    localparam int HELD_W = 3;

    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

    localparam int CFG_IDX_W = 1;
    localparam int CFG_DATA_W = GAP_W;

    localparam logic [CFG_IDX_W-1:0] CFG_LETTER_GAP = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_WORD_GAP = 1'b1;

    localparam logic [GAP_W-1:0] LETTER_GAP_RESET = 16'd180;
    localparam logic [GAP_W-1:0] WORD_GAP_RESET = 16'd420;

    localparam logic [KIND_W-1:0] KIND_DIT = 2'd0;
    localparam logic [KIND_W-1:0] KIND_DAH = 2'd1;
    localparam logic [KIND_W-1:0] KIND_TICK = 2'd2;

    localparam logic [CHAR_W-1:0] CH_DOT = 7'h2E;
    localparam logic [CHAR_W-1:0] CH_DASH = 7'h2D;
    localparam logic [CHAR_W-1:0] CH_QMARK = 7'h3F;

    typedef enum logic [1:0] {
        OP_NOP  = 2'd0,
        OP_ELEM = 2'd1,
        OP_TICK = 2'd2
    } mgd_op_t;

    typedef struct packed {
        mgd_op_t            op;
        logic               dah;
        logic [TIME_W-1:0]  now_ms;
    } mgd_item_t;

    // pattern is first element msb, dah = 1
    function automatic logic [CHAR_W-1:0] morse_lookup(input logic [2:0] len,
                                                      input logic [5:0] bits);
        logic [CHAR_W-1:0] ch;
        ch = CH_QMARK;
        case ({len, bits})
            {3'd2, 6'd1}:  ch = 7'h41;
            {3'd4, 6'd8}:  ch = 7'h42;
            {3'd4, 6'd10}: ch = 7'h43;
            {3'd3, 6'd4}:  ch = 7'h44;
            {3'd1, 6'd0}:  ch = 7'h45;
            {3'd4, 6'd2}:  ch = 7'h46;
            {3'd3, 6'd6}:  ch = 7'h47;
            {3'd4, 6'd0}:  ch = 7'h48;
            {3'd2, 6'd0}:  ch = 7'h49;
            {3'd4, 6'd7}:  ch = 7'h4A;
            {3'd3, 6'd5}:  ch = 7'h4B;
            {3'd4, 6'd4}:  ch = 7'h4C;
            {3'd2, 6'd3}:  ch = 7'h4D;
            {3'd2, 6'd2}:  ch = 7'h4E;
            {3'd3, 6'd7}:  ch = 7'h4F;
            {3'd4, 6'd6}:  ch = 7'h50;
            {3'd4, 6'd13}: ch = 7'h51;
            {3'd3, 6'd2}:  ch = 7'h52;
            {3'd3, 6'd0}:  ch = 7'h53;
            {3'd1, 6'd1}:  ch = 7'h54;
            {3'd3, 6'd1}:  ch = 7'h55;
            {3'd4, 6'd1}:  ch = 7'h56;
            {3'd3, 6'd3}:  ch = 7'h57;
            {3'd4, 6'd9}:  ch = 7'h58;
            {3'd4, 6'd11}: ch = 7'h59;
            {3'd4, 6'd12}: ch = 7'h5A;
            {3'd5, 6'd31}: ch = 7'h30;
            {3'd5, 6'd15}: ch = 7'h31;
            {3'd5, 6'd7}:  ch = 7'h32;
            {3'd5, 6'd3}:  ch = 7'h33;
            {3'd5, 6'd1}:  ch = 7'h34;
            {3'd5, 6'd0}:  ch = 7'h35;
            {3'd5, 6'd16}: ch = 7'h36;
            {3'd5, 6'd24}: ch = 7'h37;
            {3'd5, 6'd28}: ch = 7'h38;
            {3'd5, 6'd30}: ch = 7'h39;
            {3'd6, 6'd21}: ch = CH_DOT;
            {3'd6, 6'd51}: ch = 7'h2C;
            {3'd6, 6'd12}: ch = CH_QMARK;
            {3'd5, 6'd18}: ch = 7'h2F;
            {3'd5, 6'd17}: ch = 7'h3D;
            {3'd5, 6'd10}: ch = 7'h2B;
            {3'd6, 6'd33}: ch = CH_DASH;
            {3'd6, 6'd26}: ch = 7'h40;
            {3'd6, 6'd56}: ch = 7'h3A;
            {3'd6, 6'd42}: ch = 7'h3B;
            default:       ch = CH_QMARK;
        endcase
        return ch;
    endfunction

endpackage

`default_nettype wire

FILE: src/morse_gap_timed_decoder_unit.sv
// morse_gap_timed_decoder_unit: top level of the gap timed morse decoder
// instantiates mgd_front and mgd_back; uses mgd_pkg
//
// input channel in_valid/in_ready carries kind (dit, dah, tick) and now_ms.
// output channel out_valid/out_ready carries exactly one result per item:
// char_valid, char_code, word_end, elements_held.
// cfg_write/cfg_index/cfg_data set letter gap (index 0) and word gap
// (index 1) in milliseconds; write only while no item is in flight.
// an item is classified and queued in a two-entry queue, then the back end
// updates the pattern and gap timer and loads the result register.
// throughput: 1 item per cycle while out_ready is high, set by the
// combinational timer compare and table lookup in the back end.
// when out_ready is low the result register holds, the queue fills and
// in_ready drops after two more items.
// reset clears the pattern, stops gap timing, empties the queue and loads
// the gap registers with 180 and 420 ms.
`timescale 1ns / 1ps
`default_nettype none

module morse_gap_timed_decoder_unit
    import mgd_pkg::*;
#(
    parameter int MAX_ELEMENTS = MAX_ELEMENTS_DEF
)
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  cfg_write,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data,
    input  wire logic                  in_valid,
    output      logic                  in_ready,
    input  wire logic [KIND_W-1:0]     kind,
    input  wire logic [TIME_W-1:0]     now_ms,
    output      logic                  out_valid,
    input  wire logic                  out_ready,
    output      logic                  char_valid,
    output      logic [CHAR_W-1:0]     char_code,
    output      logic                  word_end,
    output      logic [HELD_W-1:0]     elements_held
);

    logic      q_valid;
    mgd_item_t q_item;
    logic      q_pop;

    mgd_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .kind     (kind),
        .now_ms   (now_ms),
        .q_valid  (q_valid),
        .q_item   (q_item),
        .q_pop    (q_pop)
    );

    mgd_back #(
        .MAX_ELEMENTS (MAX_ELEMENTS)
    ) u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_write     (cfg_write),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .q_valid       (q_valid),
        .q_item        (q_item),
        .q_pop         (q_pop),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .char_valid    (char_valid),
        .char_code     (char_code),
        .word_end      (word_end),
        .elements_held (elements_held)
    );

endmodule

`default_nettype wire

FILE: src/mgd_front.sv
// mgd_front: accepts input items, classifies them into operations and
// holds them in a two-entry queue for the back end; uses mgd_pkg
`timescale 1ns / 1ps
`default_nettype none

module mgd_front
    import mgd_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    output      logic              in_ready,
    input  wire logic [KIND_W-1:0] kind,
    input  wire logic [TIME_W-1:0] now_ms,
    output      logic              q_valid,
    output      mgd_item_t         q_item,
    input  wire logic              q_pop
);

    mgd_item_t             slot_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0]     wr_ptr_reg;
    logic [QPTR_W-1:0]     wr_ptr_next;
    logic [QPTR_W-1:0]     rd_ptr_reg;
    logic [QPTR_W-1:0]     rd_ptr_next;
    logic [QCNT_W-1:0]     count_reg;
    logic [QCNT_W-1:0]     count_next;
    mgd_item_t             item_in;
    logic                  push;
    logic                  pop;

    always_comb
    begin
        item_in.dah = kind[0];
        item_in.now_ms = now_ms;
        case (kind) inside
            KIND_DIT, KIND_DAH: item_in.op = OP_ELEM;
            KIND_TICK:          item_in.op = OP_TICK;
            default:            item_in.op = OP_NOP;
        endcase
    end

    assign in_ready = (count_reg != QCNT_W'(QUEUE_DEPTH));
    assign push = in_valid && in_ready;
    assign q_valid = (count_reg != '0);
    assign pop = q_pop && q_valid;
    assign q_item = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= item_in;
        end
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= QCNT_W'(QUEUE_DEPTH))
        else $error("queue count beyond depth");

    a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg == '0) && push |=> (count_reg == QCNT_W'(1)))
        else $error("queue lost a pushed item");

endmodule

`default_nettype wire

FILE: src/mgd_back.sv
// mgd_back: gap timing, pattern state, character lookup and the result
// register; holds the configuration registers; uses mgd_pkg
`timescale 1ns / 1ps
`default_nettype none

module mgd_back
    import mgd_pkg::*;
#(
    parameter int MAX_ELEMENTS = MAX_ELEMENTS_DEF
)
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  cfg_write,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data,
    input  wire logic                  q_valid,
    input  wire mgd_item_t             q_item,
    output      logic                  q_pop,
    output      logic                  out_valid,
    input  wire logic                  out_ready,
    output      logic                  char_valid,
    output      logic [CHAR_W-1:0]     char_code,
    output      logic                  word_end,
    output      logic [HELD_W-1:0]     elements_held
);

    localparam int LEN_W = $clog2(MAX_ELEMENTS + 1);

    logic [GAP_W-1:0]        letter_gap_reg;
    logic [GAP_W-1:0]        word_gap_reg;
    logic [MAX_ELEMENTS-1:0] bits_reg;
    logic [MAX_ELEMENTS-1:0] bits_next;
    logic [LEN_W-1:0]        len_reg;
    logic [LEN_W-1:0]        len_next;
    logic [TIME_W-1:0]       last_reg;
    logic [TIME_W-1:0]       last_next;
    logic                    active_reg;
    logic                    active_next;
    logic                    o_valid_reg;
    logic                    o_valid_next;
    logic                    char_valid_reg;
    logic                    char_valid_next;
    logic [CHAR_W-1:0]       char_code_reg;
    logic [CHAR_W-1:0]       char_code_next;
    logic                    word_end_reg;
    logic                    word_end_next;
    logic [HELD_W-1:0]       held_reg;
    logic [HELD_W-1:0]       held_next;
    logic [TIME_W-1:0]       elapsed;
    logic                    word_hit;
    logic                    letter_hit;
    logic [CHAR_W-1:0]       looked_up;

    assign q_pop = q_valid && (!o_valid_reg || out_ready);

    // elapsed time wraps modulo 2^32
    assign elapsed = q_item.now_ms - last_reg;
    assign word_hit = elapsed >= {{(TIME_W - GAP_W){1'b0}}, word_gap_reg};
    assign letter_hit = elapsed >= {{(TIME_W - GAP_W){1'b0}}, letter_gap_reg};
    assign looked_up = (len_reg > LEN_W'(LOOKUP_MAX_LEN)) ? CH_QMARK
                     : morse_lookup(len_reg[2:0], bits_reg[5:0]);

    always_comb
    begin
        bits_next = bits_reg;
        len_next = len_reg;
        last_next = last_reg;
        active_next = active_reg;
        char_valid_next = 1'b0;
        char_code_next = '0;
        word_end_next = 1'b0;
        case (q_item.op)
            OP_ELEM:
            begin
                // elements past capacity are dropped but still restart the timer
                if (len_reg < LEN_W'(MAX_ELEMENTS))
                begin
                    bits_next = {bits_reg[MAX_ELEMENTS-2:0], q_item.dah};
                    len_next = len_reg + 1'b1;
                end
                last_next = q_item.now_ms;
                active_next = 1'b1;
            end
            OP_TICK:
            begin
                if (active_reg)
                begin
                    if ((word_hit || letter_hit) && (len_reg != '0))
                    begin
                        char_valid_next = 1'b1;
                        char_code_next = looked_up;
                        bits_next = '0;
                        len_next = '0;
                    end
                    if (word_hit)
                    begin
                        word_end_next = 1'b1;
                        active_next = 1'b0;
                    end
                end
            end
            default:
            begin
            end
        endcase
        held_next = len_next[HELD_W-1:0];
        o_valid_next = o_valid_reg && !out_ready;
        if (q_pop)
        begin
            o_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            letter_gap_reg <= LETTER_GAP_RESET;
            word_gap_reg <= WORD_GAP_RESET;
            bits_reg <= '0;
            len_reg <= '0;
            last_reg <= '0;
            active_reg <= 1'b0;
            o_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_write)
            begin
                case (cfg_index)
                    CFG_LETTER_GAP: letter_gap_reg <= cfg_data;
                    CFG_WORD_GAP:   word_gap_reg <= cfg_data;
                    default:
                    begin
                    end
                endcase
            end
            if (q_pop)
            begin
                bits_reg <= bits_next;
                len_reg <= len_next;
                last_reg <= last_next;
                active_reg <= active_next;
            end
            o_valid_reg <= o_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            char_valid_reg <= char_valid_next;
            char_code_reg <= char_code_next;
            word_end_reg <= word_end_next;
            held_reg <= held_next;
        end
    end

    assign out_valid = o_valid_reg;
    assign char_valid = char_valid_reg;
    assign char_code = char_code_reg;
    assign word_end = word_end_reg;
    assign elements_held = held_reg;

    a_len_bound: assert property (@(posedge clk) disable iff (!rst_n)
        len_reg <= LEN_W'(MAX_ELEMENTS))
        else $error("pattern length beyond capacity");

    a_elem_arms: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop && (q_item.op == OP_ELEM) |=> active_reg && (len_reg != '0))
        else $error("element did not arm gap timing");

    a_char_clears: assert property (@(posedge clk) disable iff (!rst_n)
        o_valid_reg && (char_valid_reg || word_end_reg) |-> (held_reg == '0))
        else $error("finalized item left elements pending");

    a_word_stops: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop && (q_item.op == OP_TICK) && active_reg && word_hit |=> !active_reg)
        else $error("word gap did not stop timing");

endmodule

`default_nettype wire
